/* hw/rtl/bpf_pkg.sv */
`default_nettype none

package bpf_pkg;

  // Sync bytes that open every packet.
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Depth of the queue between the classifier and the serialiser.
  localparam int BPF_QUEUE_DEPTH = 4;

  // One classified input word, as handed from the front end to the back end.
  typedef struct packed {
    logic        first;    // opens a message: header bytes go out first
    logic        has_pay;  // the payload byte is sent and summed
    logic        done;     // the message ends: both checksum bytes follow
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    logic [7:0]  data;
  } bpf_item_t;

endpackage

`default_nettype wire

/* hw/rtl/bpf_front.sv */
`default_nettype none

module bpf_front
  import bpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic [7:0]  cls,
  input  wire logic [7:0]  id,
  input  wire logic [15:0] len,
  input  wire logic [7:0]  data,
  output bpf_item_t        item
);

  logic [15:0] pos_r;
  logic [15:0] pos_nxt;
  logic [15:0] pos_adv;
  logic        first;
  logic        has_pay;
  logic        done;

  // The position counts payload bytes sent so far; zero means a new message.
  always_comb begin
    first = (pos_r == 16'd0);
    if (first) begin
      has_pay = (len != 16'd0);
      pos_adv = has_pay ? 16'd1 : 16'd0;
    end else begin
      has_pay = 1'b1;
      pos_adv = (pos_r == 16'hFFFF) ? pos_r : pos_r + 16'd1;
    end
    done    = (pos_adv >= len);
    pos_nxt = pos_r;
    if (acc) begin
      pos_nxt = done ? 16'd0 : pos_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 16'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  assign item = '{first: first, has_pay: has_pay, done: done,
                  cls: cls, id: id, len: len, data: data};

endmodule

`default_nettype wire

/* hw/rtl/bpf_queue.sv */
`default_nettype none

module bpf_queue
  import bpf_pkg::*;
#(
  parameter int QueueDepth = BPF_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire bpf_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           head_valid,
  output bpf_item_t      head_item
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  bpf_item_t         mem_r [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign full       = (count_r == CntW'(QueueDepth));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

/* hw/rtl/bpf_back.sv */
`default_nettype none

module bpf_back
  import bpf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  wire bpf_item_t  head_item,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  // Byte kinds, in the order they appear on the wire.
  localparam logic [3:0] K_SYNC1 = 4'd0;
  localparam logic [3:0] K_SYNC2 = 4'd1;
  localparam logic [3:0] K_CLS   = 4'd2;
  localparam logic [3:0] K_ID    = 4'd3;
  localparam logic [3:0] K_LENL  = 4'd4;
  localparam logic [3:0] K_LENH  = 4'd5;
  localparam logic [3:0] K_DATA  = 4'd6;
  localparam logic [3:0] K_SUMA  = 4'd7;
  localparam logic [3:0] K_SUMB  = 4'd8;

  logic [3:0] kind_r, kind_nxt;
  logic       busy_r, busy_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic [7:0] sum_a_r, sum_a_nxt;
  logic [7:0] sum_b_r, sum_b_nxt;

  logic [3:0] cur_kind;
  logic [3:0] next_kind;
  logic       item_end;
  logic       advance;
  logic       summed;
  logic [7:0] cur_byte;

  always_comb begin
    cur_kind = busy_r ? kind_r : (head_item.first ? K_SYNC1 : K_DATA);
    advance  = !valid_r || out_ready;

    cur_byte  = 8'd0;
    next_kind = cur_kind + 4'd1;
    item_end  = 1'b0;
    unique case (cur_kind)
      K_SYNC1: cur_byte = SYNC_FIRST;
      K_SYNC2: cur_byte = SYNC_SECOND;
      K_CLS:   cur_byte = head_item.cls;
      K_ID:    cur_byte = head_item.id;
      K_LENL:  cur_byte = head_item.len[7:0];
      K_LENH: begin
        cur_byte = head_item.len[15:8];
        if (head_item.has_pay) begin
          next_kind = K_DATA;
        end else if (head_item.done) begin
          next_kind = K_SUMA;
        end else begin
          item_end = 1'b1;
        end
      end
      K_DATA: begin
        cur_byte = head_item.data;
        if (head_item.done) begin
          next_kind = K_SUMA;
        end else begin
          item_end = 1'b1;
        end
      end
      K_SUMA:  cur_byte = sum_a_r;
      K_SUMB: begin
        cur_byte = sum_b_r;
        item_end = 1'b1;
      end
      default: item_end = 1'b1;
    endcase

    summed = (cur_kind == K_CLS) || (cur_kind == K_ID) || (cur_kind == K_LENL) ||
             (cur_kind == K_LENH) || (cur_kind == K_DATA);

    pop       = 1'b0;
    kind_nxt  = kind_r;
    busy_nxt  = busy_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;

    if (advance) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        byte_nxt = cur_byte;
        last_nxt = (cur_kind == K_SUMB);
        if (cur_kind == K_SYNC1 || cur_kind == K_SUMB) begin
          sum_a_nxt = 8'd0;
          sum_b_nxt = 8'd0;
        end else if (summed) begin
          sum_a_nxt = sum_a_r + cur_byte;
          sum_b_nxt = sum_b_r + sum_a_nxt;
        end
        if (item_end) begin
          pop      = 1'b1;
          busy_nxt = 1'b0;
        end else begin
          busy_nxt = 1'b1;
          kind_nxt = next_kind;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      kind_r  <= K_SYNC1;
      sum_a_r <= 8'd0;
      sum_b_r <= 8'd0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
      kind_r  <= kind_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

/* hw/rtl/binary_packet_framer_fletcher8.sv */
// An accepted word is queued, then its first byte leaves via the registered output stage.
// Throughput: one byte per cycle while out_tready holds, paced by the byte output port.
// Per word: one byte mid-message, six or seven to open, two more checksum bytes to close.
// Input words keep arriving at one per cycle while the queue has room.
// Reset: synchronous, active low; clears the byte position, the sums, the queue and the output.
`default_nettype none

module binary_packet_framer_fletcher8
  import bpf_pkg::*;
#(
  parameter int QueueDepth = BPF_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input words, at most one payload byte each.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // msg_class[7:0], msg_id[15:8],
                                        // payload_length[31:16], payload_byte[39:32]
  // Framed packet bytes.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // out_byte[7:0]
  output logic             out_tlast   // frame_end: set on the final checksum byte
);

  // The front end keeps the byte position of the current message and tags every word
  // with whether it opens the message, carries a payload byte and closes the message.
  // Tagged words wait in a short queue, so the input side only waits once the queue is full.

  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_valid;
  bpf_item_t front_item;
  bpf_item_t q_item;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  bpf_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (q_push),
    .cls   (in_tdata[7:0]),
    .id    (in_tdata[15:8]),
    .len   (in_tdata[31:16]),
    .data  (in_tdata[39:32]),
    .item  (front_item)
  );

  bpf_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  // The back end walks each tagged word through its bytes, keeps the Fletcher sums
  // over class, id, length and payload, and holds one byte in a registered output stage.
  bpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_item  (q_item),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

`ifndef SYNTH
  // Only a word that is present can be retired.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // An empty message opens and closes on the same word without payload.
  a_empty_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_item.first && q_item.len == 16'd0) |-> (q_item.done && !q_item.has_pay))
    else $error("empty message tagged wrongly");

  // A word inside a message always carries a payload byte.
  a_mid_pay: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !q_item.first) |-> q_item.has_pay)
    else $error("continuation word without payload");
`endif

endmodule

`default_nettype wire
